### sv/bstk_pkg.sv
// bstk_pkg: shared types and constants for the bounded stack with search
// no dependencies
package bstk_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = 7;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_PEEK   = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_top;
    logic scan_start;
    logic scan_en;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic empty;
    logic scan_hit;
    logic scan_miss;
    logic out_free;
  } dp_stat_t;

endpackage

### sv/bstk_req_if.sv
// bstk_req_if: request channel carrying command and value
// depends on bstk_pkg
interface bstk_req_if import bstk_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [1:0]               command;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, command, value, input ready);
  modport sink   (input valid, command, value, output ready);
endinterface

### sv/bstk_rsp_if.sv
// bstk_rsp_if: result channel carrying status, data, flags and count
// depends on bstk_pkg
interface bstk_rsp_if import bstk_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] data;
  logic                     is_full;
  logic                     is_empty;
  logic [CNT_W-1:0]         count;

  modport source (output valid, status, data, is_full, is_empty, count, input ready);
  modport sink   (input valid, status, data, is_full, is_empty, count, output ready);
endinterface

### sv/bstk_ctrl.sv
// bstk_ctrl: sequencing state machine for one request at a time
// depends on bstk_pkg
module bstk_ctrl import bstk_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t ctl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    req_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = !rst;
        if (req_valid && !rst) begin
          ctl.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.cmd)
          CMD_POP, CMD_PEEK: begin
            ctl.rd_top = !stat.empty;
            state_next = S_FINISH;
          end
          CMD_SEARCH: begin
            if (stat.empty) begin
              state_next = S_FINISH;
            end else begin
              ctl.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_SCAN: begin
        ctl.scan_en = 1'b1;
        if (stat.scan_hit || stat.scan_miss) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### sv/bstk_dp.sv
// bstk_dp: entry memory, count and capacity registers, scan pipeline, result register
// depends on bstk_pkg
module bstk_dp import bstk_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  ctrl_cmd_t                ctl,
  output dp_stat_t                 stat,
  input  logic [1:0]               in_command,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     cfg_wr_en,
  input  logic [CNT_W-1:0]         cfg_wr_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               out_status,
  output logic signed [DATA_W-1:0] out_data,
  output logic                     out_is_full,
  output logic                     out_is_empty,
  output logic [CNT_W-1:0]         out_count
);

  logic [DATA_W-1:0] mem [DEPTH];

  cmd_t              cmd;
  logic [DATA_W-1:0] key;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  capacity;
  logic [CNT_W-1:0]  eff_cap;
  logic [CNT_W-1:0]  idx;
  logic [ADDR_W-1:0] cmp_idx;
  logic              cmp_valid;
  logic              found;
  logic [ADDR_W-1:0] found_idx;
  logic [DATA_W-1:0] rdata;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic              full_now;
  logic              issue;
  status_t           res_status;
  logic [DATA_W-1:0] res_data;

  assign eff_cap  = (capacity > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : capacity;
  assign full_now = (count >= eff_cap);
  assign issue    = ctl.scan_en && (idx < count);

  assign rd_en   = ctl.rd_top || issue;
  assign rd_addr = ctl.rd_top ? ADDR_W'(count - CNT_W'(1)) : idx[ADDR_W-1:0];

  assign stat.cmd       = cmd;
  assign stat.empty     = (count == '0);
  assign stat.scan_hit  = cmp_valid && (rdata == key);
  assign stat.scan_miss = cmp_valid && (rdata != key) &&
                          (CNT_W'(cmp_idx) == count - CNT_W'(1));
  assign stat.out_free  = !out_valid || out_ready;

  always_comb begin
    res_status = ST_OK;
    res_data   = '0;
    count_next = count;
    wr_en      = 1'b0;
    case (cmd)
      CMD_PUSH: begin
        if (full_now) begin
          res_status = ST_OVERFLOW;
        end else begin
          wr_en      = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      CMD_POP: begin
        if (count == '0) begin
          res_status = ST_UNDERFLOW;
        end else begin
          res_data   = rdata;
          count_next = count - CNT_W'(1);
        end
      end
      CMD_PEEK: begin
        if (count == '0) begin
          res_status = ST_UNDERFLOW;
        end else begin
          res_data = rdata;
        end
      end
      default: begin
        if (found) begin
          res_data = DATA_W'(found_idx);
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.finish && wr_en) begin
      mem[count[ADDR_W-1:0]] <= key;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd <= cmd_t'(in_command);
      key <= in_value;
    end
    if (ctl.scan_start) begin
      idx <= '0;
    end else if (issue) begin
      idx     <= idx + CNT_W'(1);
      cmp_idx <= idx[ADDR_W-1:0];
    end
    if (ctl.scan_en && stat.scan_hit) begin
      found_idx <= cmp_idx;
    end
    if (ctl.finish) begin
      out_status   <= res_status;
      out_data     <= res_data;
      out_is_full  <= (count_next >= eff_cap);
      out_is_empty <= (count_next == '0);
      out_count    <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      capacity  <= CNT_W'(DEPTH);
      cmp_valid <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      if (ctl.finish) begin
        count <= count_next;
      end
      if (ctl.load) begin
        found <= 1'b0;
      end else if (ctl.scan_en && stat.scan_hit) begin
        found <= 1'b1;
      end
      if (ctl.scan_start) begin
        cmp_valid <= 1'b0;
      end else if (ctl.scan_en) begin
        cmp_valid <= issue;
      end
      if (ctl.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### sv/bounded_stack_with_search_top.sv
// bounded_stack_with_search_top: one request at a time through controller and datapath
// push, pop and peek: accepted in idle, then decode and finish states; pop and peek read the top entry when not empty
// search: one entry per cycle through the single memory read port
// next request is taken the cycle after a result is registered, even if it is not yet taken
// rst (synchronous): count 0, capacity 64, no result pending; entry memory is not cleared
module bounded_stack_with_search_top import bstk_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  bstk_req_if.sink         req,
  bstk_rsp_if.source       rsp,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data
);

  ctrl_cmd_t ctl;
  dp_stat_t  stat;

  bstk_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  bstk_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .stat         (stat),
    .in_command   (req.command),
    .in_value     (req.value),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .out_status   (rsp.status),
    .out_data     (rsp.data),
    .out_is_full  (rsp.is_full),
    .out_is_empty (rsp.is_empty),
    .out_count    (rsp.count)
  );

endmodule
